// ----- src/two_speed_homing_sequencer_core_defines.svh -----
// Assertion macros for the two-speed homing sequencer.
// Taken in by the top level; relies on nothing else.
`ifndef TWO_SPEED_HOMING_SEQUENCER_CORE_DEFINES_SVH
`define TWO_SPEED_HOMING_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define THSQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("homing sequencer check failed");

// Next-cycle implication, checked outside reset.
`define THSQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("homing sequencer check failed");

`endif

// ----- src/thsq_pkg.sv -----
// Shared types, codes and constants of the two-speed homing sequencer.
// No dependencies.
package thsq_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int RATE_W     = 20;
    localparam int TMO_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int CMD_W      = 3;
    localparam int NOW_W      = 32;
    localparam int PHASE_W    = 4;
    localparam int DRV_W      = 2;

    localparam logic [CMD_W-1:0] CMD_TICK          = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_FAST    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START_BACKOFF = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GO_IDLE       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MARK_HOME     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SEEK_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SEEK_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_TIMEOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_TIMEOUT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_TIMEOUT     = 3'd5;

    localparam logic [RATE_W-1:0] RST_FAST_SEEK_RATE   = 20'd40000;
    localparam logic [RATE_W-1:0] RST_SLOW_SEEK_RATE   = 20'd2000;
    localparam logic [RATE_W-1:0] RST_BACKOFF_DISTANCE = 20'd2000;
    localparam logic [TMO_W-1:0]  RST_FAST_TIMEOUT     = 16'd15000;
    localparam logic [TMO_W-1:0]  RST_BACKOFF_TIMEOUT  = 16'd3000;
    localparam logic [TMO_W-1:0]  RST_SLOW_TIMEOUT     = 16'd8000;

    localparam logic [PHASE_W-1:0] PH_CODE_IDLE         = 4'd0;
    localparam logic [PHASE_W-1:0] PH_CODE_FAST_SEEK    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CODE_FAST_WAIT    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_CODE_BACKOFF      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_CODE_BACKOFF_WAIT = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CODE_SLOW_SEEK    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CODE_SLOW_WAIT    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_CODE_COMPLETE     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_CODE_FAILED       = 4'd8;

    typedef enum logic [8:0] {
        PH_IDLE         = 9'b000000001,
        PH_FAST_SEEK    = 9'b000000010,
        PH_FAST_WAIT    = 9'b000000100,
        PH_BACKOFF      = 9'b000001000,
        PH_BACKOFF_WAIT = 9'b000010000,
        PH_SLOW_SEEK    = 9'b000100000,
        PH_SLOW_WAIT    = 9'b001000000,
        PH_COMPLETE     = 9'b010000000,
        PH_FAILED       = 9'b100000000
    } phase_t;

    typedef enum logic [DRV_W-1:0] {
        DRV_NONE     = 2'd0,
        DRV_VEL      = 2'd1,
        DRV_MOVE_NEG = 2'd2,
        DRV_STOP     = 2'd3
    } drive_t;

    typedef struct packed {
        logic [RATE_W-1:0] fast_seek_rate;
        logic [RATE_W-1:0] slow_seek_rate;
        logic [RATE_W-1:0] backoff_distance;
        logic [TMO_W-1:0]  fast_timeout;
        logic [TMO_W-1:0]  backoff_timeout;
        logic [TMO_W-1:0]  slow_timeout;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [NOW_W-1:0] now_ms;
        logic             home_tripped;
        logic             limit_cancel;
        logic             alerts_present;
        logic             steps_complete;
    } item_t;

    typedef struct packed {
        phase_t                phase;
        logic [TIME_WIDTH-1:0] entry;
        logic                  homed;
    } state_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               homed;
        drive_t             drive_cmd;
        logic [RATE_W-1:0]  drive_amount;
        logic               zero_reference;
    } result_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        logic [PHASE_W-1:0] c;
        case (p)
            PH_IDLE:         c = PH_CODE_IDLE;
            PH_FAST_SEEK:    c = PH_CODE_FAST_SEEK;
            PH_FAST_WAIT:    c = PH_CODE_FAST_WAIT;
            PH_BACKOFF:      c = PH_CODE_BACKOFF;
            PH_BACKOFF_WAIT: c = PH_CODE_BACKOFF_WAIT;
            PH_SLOW_SEEK:    c = PH_CODE_SLOW_SEEK;
            PH_SLOW_WAIT:    c = PH_CODE_SLOW_WAIT;
            PH_COMPLETE:     c = PH_CODE_COMPLETE;
            PH_FAILED:       c = PH_CODE_FAILED;
            default:         c = PH_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ----- src/thsq_cfg_regs.sv -----
// Configuration register file of the homing sequencer: rates, backoff, timeouts.
// Depends on thsq_pkg.
module thsq_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [thsq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [thsq_pkg::CFG_DATA_W-1:0]  cfg_data,
    output thsq_pkg::cfg_t                   cfg
);

    thsq_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_seek_rate   <= thsq_pkg::RST_FAST_SEEK_RATE;
            cfg_reg.slow_seek_rate   <= thsq_pkg::RST_SLOW_SEEK_RATE;
            cfg_reg.backoff_distance <= thsq_pkg::RST_BACKOFF_DISTANCE;
            cfg_reg.fast_timeout     <= thsq_pkg::RST_FAST_TIMEOUT;
            cfg_reg.backoff_timeout  <= thsq_pkg::RST_BACKOFF_TIMEOUT;
            cfg_reg.slow_timeout     <= thsq_pkg::RST_SLOW_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                thsq_pkg::CFG_FAST_SEEK_RATE:
                    cfg_reg.fast_seek_rate <= cfg_data[thsq_pkg::RATE_W-1:0];
                thsq_pkg::CFG_SLOW_SEEK_RATE:
                    cfg_reg.slow_seek_rate <= cfg_data[thsq_pkg::RATE_W-1:0];
                thsq_pkg::CFG_BACKOFF_DISTANCE:
                    cfg_reg.backoff_distance <= cfg_data[thsq_pkg::RATE_W-1:0];
                thsq_pkg::CFG_FAST_TIMEOUT:
                    cfg_reg.fast_timeout <= cfg_data[thsq_pkg::TMO_W-1:0];
                thsq_pkg::CFG_BACKOFF_TIMEOUT:
                    cfg_reg.backoff_timeout <= cfg_data[thsq_pkg::TMO_W-1:0];
                thsq_pkg::CFG_SLOW_TIMEOUT:
                    cfg_reg.slow_timeout <= cfg_data[thsq_pkg::TMO_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/thsq_step.sv -----
// One tick of the homing phase machine: command, then one phase step.
// Pure combinational; depends on thsq_pkg.
module thsq_step (
    input  thsq_pkg::item_t   item,
    input  thsq_pkg::state_t  state,
    input  thsq_pkg::cfg_t    cfg,
    output thsq_pkg::state_t  state_next,
    output thsq_pkg::result_t result
);

    logic [thsq_pkg::TIME_WIDTH-1:0] now_t;

    assign now_t = thsq_pkg::TIME_WIDTH'(item.now_ms);

    always_comb
    begin
        thsq_pkg::phase_t                phase;
        logic [thsq_pkg::TIME_WIDTH-1:0] entry;
        logic [thsq_pkg::TIME_WIDTH-1:0] elapsed;
        logic                            homed;
        thsq_pkg::drive_t                dcmd;
        logic [thsq_pkg::RATE_W-1:0]     amount;
        logic                            zref;

        phase   = state.phase;
        entry   = state.entry;
        homed   = state.homed;
        dcmd    = thsq_pkg::DRV_NONE;
        amount  = '0;
        zref    = 1'b0;
        elapsed = '0;

        case (item.cmd)
            thsq_pkg::CMD_START_FAST:
            begin
                homed = 1'b0;
                phase = thsq_pkg::PH_FAST_SEEK;
                entry = now_t;
            end
            thsq_pkg::CMD_START_BACKOFF:
            begin
                homed = 1'b0;
                phase = thsq_pkg::PH_BACKOFF;
                entry = now_t;
            end
            thsq_pkg::CMD_GO_IDLE:
            begin
                dcmd  = thsq_pkg::DRV_STOP;
                phase = thsq_pkg::PH_IDLE;
                entry = now_t;
            end
            thsq_pkg::CMD_MARK_HOME:
            begin
                zref  = 1'b1;
                homed = 1'b1;
                phase = thsq_pkg::PH_COMPLETE;
                entry = now_t;
            end
            default:
                ;
        endcase

        // Later actions in a tick override earlier ones; an earlier phase
        // entry restarts the elapsed time seen by the timeout check.
        case (phase)
            thsq_pkg::PH_FAST_SEEK:
            begin
                dcmd   = thsq_pkg::DRV_VEL;
                amount = cfg.fast_seek_rate;
                phase  = thsq_pkg::PH_FAST_WAIT;
                entry  = now_t;
            end
            thsq_pkg::PH_FAST_WAIT:
            begin
                if (item.limit_cancel && item.steps_complete)
                begin
                    zref  = 1'b1;
                    phase = thsq_pkg::PH_BACKOFF;
                    entry = now_t;
                end
                if (item.alerts_present && !item.limit_cancel)
                begin
                    phase = thsq_pkg::PH_FAILED;
                    entry = now_t;
                end
                elapsed = now_t - entry;
                if (elapsed >= thsq_pkg::TIME_WIDTH'(cfg.fast_timeout))
                begin
                    dcmd   = thsq_pkg::DRV_STOP;
                    amount = '0;
                    phase  = thsq_pkg::PH_FAILED;
                    entry  = now_t;
                end
            end
            thsq_pkg::PH_BACKOFF:
            begin
                dcmd   = thsq_pkg::DRV_MOVE_NEG;
                amount = cfg.backoff_distance;
                phase  = thsq_pkg::PH_BACKOFF_WAIT;
                entry  = now_t;
            end
            thsq_pkg::PH_BACKOFF_WAIT:
            begin
                if (!item.home_tripped)
                begin
                    dcmd   = thsq_pkg::DRV_STOP;
                    amount = '0;
                    if (item.steps_complete)
                    begin
                        phase = thsq_pkg::PH_SLOW_SEEK;
                        entry = now_t;
                    end
                end
                else if (item.steps_complete)
                begin
                    phase = thsq_pkg::PH_FAILED;
                    entry = now_t;
                end
                if (item.alerts_present)
                begin
                    phase = thsq_pkg::PH_FAILED;
                    entry = now_t;
                end
                elapsed = now_t - entry;
                if (elapsed >= thsq_pkg::TIME_WIDTH'(cfg.backoff_timeout))
                begin
                    dcmd   = thsq_pkg::DRV_STOP;
                    amount = '0;
                    phase  = thsq_pkg::PH_FAILED;
                    entry  = now_t;
                end
            end
            thsq_pkg::PH_SLOW_SEEK:
            begin
                dcmd   = thsq_pkg::DRV_VEL;
                amount = cfg.slow_seek_rate;
                phase  = thsq_pkg::PH_SLOW_WAIT;
                entry  = now_t;
            end
            thsq_pkg::PH_SLOW_WAIT:
            begin
                if (item.limit_cancel && item.steps_complete)
                begin
                    zref  = 1'b1;
                    homed = 1'b1;
                    phase = thsq_pkg::PH_COMPLETE;
                    entry = now_t;
                end
                if (item.alerts_present && !item.limit_cancel)
                begin
                    phase = thsq_pkg::PH_FAILED;
                    entry = now_t;
                end
                elapsed = now_t - entry;
                if (elapsed >= thsq_pkg::TIME_WIDTH'(cfg.slow_timeout))
                begin
                    dcmd   = thsq_pkg::DRV_STOP;
                    amount = '0;
                    phase  = thsq_pkg::PH_FAILED;
                    entry  = now_t;
                end
            end
            default:
                ;
        endcase

        state_next.phase      = phase;
        state_next.entry      = entry;
        state_next.homed      = homed;
        result.phase          = thsq_pkg::phase_code(phase);
        result.homed          = homed;
        result.drive_cmd      = dcmd;
        result.drive_amount   = amount;
        result.zero_reference = zref;
    end

endmodule

// ----- src/two_speed_homing_sequencer_core.sv -----
// Top level of the two-speed homing sequencer: input, state and result registers.
// Depends on thsq_pkg, thsq_cfg_regs, thsq_step and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one control tick: cmd, now_ms,
//   home_tripped, limit_cancel, alerts_present, steps_complete.
//   Output channel (out_valid/out_ready) returns exactly one result per tick:
//   phase, homed, drive_cmd, drive_amount, zero_reference.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes one register
//   per cycle with no wait; index 0..5 selects fast rate, slow rate, backoff
//   distance, fast, backoff and slow timeouts. Other indexes are ignored.
//   The input register takes an accepted tick; the phase step logic then writes
//   its result into the output register once that register is free or being
//   drained. Throughput: one tick per cycle while the receiver takes results,
//   set by the single register-to-register pass through the phase step logic.
//   When the receiver stalls, the result holds in the output register and one
//   more tick waits in the input register; in_ready then drops until the
//   result is taken.
//   Reset puts the phase to idle, clears homed and the entry time, empties
//   both registers and loads the register defaults.
`include "two_speed_homing_sequencer_core_defines.svh"

module two_speed_homing_sequencer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [thsq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [thsq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [thsq_pkg::CMD_W-1:0]       cmd,
    input  logic [thsq_pkg::NOW_W-1:0]       now_ms,
    input  logic                             home_tripped,
    input  logic                             limit_cancel,
    input  logic                             alerts_present,
    input  logic                             steps_complete,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [thsq_pkg::PHASE_W-1:0]     phase,
    output logic                             homed,
    output logic [thsq_pkg::DRV_W-1:0]       drive_cmd,
    output logic [thsq_pkg::RATE_W-1:0]      drive_amount,
    output logic                             zero_reference
);

    thsq_pkg::cfg_t    cfg;
    thsq_pkg::item_t   item_reg;
    logic              s1_valid_reg;
    thsq_pkg::state_t  state_reg;
    thsq_pkg::state_t  state_next;
    thsq_pkg::result_t result_next;
    thsq_pkg::result_t result_reg;
    logic              out_valid_reg;
    logic              s1_advance;
    logic              in_transfer;

    thsq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    thsq_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Advance the held tick when the output register is free or being drained.
    assign s1_advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready    = !s1_valid_reg || s1_advance;
    assign in_transfer = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_transfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            item_reg.cmd            <= cmd;
            item_reg.now_ms         <= now_ms;
            item_reg.home_tripped   <= home_tripped;
            item_reg.limit_cancel   <= limit_cancel;
            item_reg.alerts_present <= alerts_present;
            item_reg.steps_complete <= steps_complete;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= thsq_pkg::PH_IDLE;
            state_reg.entry <= '0;
            state_reg.homed <= 1'b0;
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign phase          = result_reg.phase;
    assign homed          = result_reg.homed;
    assign drive_cmd      = result_reg.drive_cmd;
    assign drive_amount   = result_reg.drive_amount;
    assign zero_reference = result_reg.zero_reference;

    // Zeroing the reference only happens on mark, limit latch or a timeout after it.
    `THSQ_ASSERT_NOW(a_zero_ref_phase, clk, rst_n, out_valid && zero_reference, phase == thsq_pkg::PH_CODE_BACKOFF || phase == thsq_pkg::PH_CODE_COMPLETE || phase == thsq_pkg::PH_CODE_FAILED)

    // A velocity move is issued only on entry to a wait phase.
    `THSQ_ASSERT_NOW(a_vel_phase, clk, rst_n, out_valid && drive_cmd == thsq_pkg::DRV_VEL, phase == thsq_pkg::PH_CODE_FAST_WAIT || phase == thsq_pkg::PH_CODE_SLOW_WAIT)

    // Phase state moves only when a tick passes through the step logic.
    `THSQ_ASSERT_NEXT(a_state_hold, clk, rst_n, !s1_valid_reg, $stable(state_reg))

endmodule
